### src/cdi_pkg.sv
package cdi_pkg;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int WD_W     = 3;
    localparam int MLEN_W   = 5;
    localparam int LIY_W    = 9;

    // Internal widths
    localparam int YY_W     = 15;   // year + 400, up to 16783
    localparam int SUM_W    = 15;   // weekday sum, below 21100
    localparam int Q100_W   = 8;    // yy / 100, up to 167
    localparam int Q7_W     = 12;   // sum / 7, up to 3012
    localparam int DOY_W    = 10;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    // Reciprocal constants: x / 100 = (x * 5243) >> 19 for x < 43690,
    // x / 7 = (x * 18725) >> 17 for x < 43690.
    localparam logic [12:0] RECIP100    = 13'd5243;
    localparam int          RECIP100_SH = 19;
    localparam logic [14:0] RECIP7      = 15'd18725;
    localparam int          RECIP7_SH   = 17;

    localparam logic [YY_W-1:0]    YEAR_BIAS = 15'd400;
    localparam logic [MONTH_W-1:0] MON_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MON_DEC   = 4'd12;
    localparam logic [WD_W-1:0]    WD_FRI    = 3'd5;
    localparam logic [WD_W-1:0]    WD_SAT    = 3'd6;

    // Handoff from the arithmetic pipe to the output stage
    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [Q7_W-1:0]   q7;
        logic              date_ok;
        logic              leap;
        logic [MLEN_W-1:0] mlen;
        logic [MLEN_W-1:0] left_month;
        logic [LIY_W-1:0]  left_year;
    } pipe_t;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [1:0]        pad;
        logic [LIY_W-1:0]  left_in_year;
        logic [MLEN_W-1:0] left_in_month;
        logic [WD_W-1:0]   left_in_week;
        logic              business_day;
        logic              weekend_flag;
        logic              end_of_week;
        logic [WD_W-1:0]   weekday;
        logic [MLEN_W-1:0] month_length;
        logic              leap_year;
        logic              date_valid;
    } result_t;

    // Days in a common year; 0 for an invalid month
    function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] m);
        logic [MLEN_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
            4'd2:                                        r = 5'd28;
            default:                                     r = 5'd0;
        endcase
        return r;
    endfunction

    // Days before the first of the month in a common year
    function automatic logic [LIY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [LIY_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // floor(31 * mm / 12) for the March-based month mm
    function automatic logic [4:0] month_offset(input logic [MONTH_W-1:0] mm);
        logic [4:0] r;
        case (mm)
            4'd1:    r = 5'd2;
            4'd2:    r = 5'd5;
            4'd3:    r = 5'd7;
            4'd4:    r = 5'd10;
            4'd5:    r = 5'd12;
            4'd6:    r = 5'd15;
            4'd7:    r = 5'd18;
            4'd8:    r = 5'd20;
            4'd9:    r = 5'd23;
            4'd10:   r = 5'd25;
            4'd11:   r = 5'd28;
            4'd12:   r = 5'd31;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

### src/cdi_pipe.sv
module cdi_pipe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cdi_pkg::YEAR_W-1:0]    in_year,
    input  logic [cdi_pkg::MONTH_W-1:0]   in_month,
    input  logic [cdi_pkg::DAY_W-1:0]     in_day,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cdi_pkg::pipe_t                out_data
);

    // Stage 1: year / 100 for the leap test, shifted year for the weekday
    logic                          v1_reg;
    logic [cdi_pkg::YEAR_W-1:0]    y1_reg;
    logic [cdi_pkg::MONTH_W-1:0]   m1_reg, mm1_reg;
    logic [cdi_pkg::DAY_W-1:0]     d1_reg;
    logic [cdi_pkg::YY_W-1:0]      yy1_reg;
    logic [cdi_pkg::Q100_W-1:0]    qy1_reg;

    // Stage 2: leap flag, shifted year / 100
    logic                          v2_reg;
    logic                          leap2_reg;
    logic [cdi_pkg::MONTH_W-1:0]   m2_reg, mm2_reg;
    logic [cdi_pkg::DAY_W-1:0]     d2_reg;
    logic [cdi_pkg::YY_W-1:0]      yy2_reg;
    logic [cdi_pkg::Q100_W-1:0]    qw2_reg;

    // Stage 3: weekday sum, month facts
    logic                          v3_reg;
    logic [cdi_pkg::SUM_W-1:0]     s3_reg;
    logic                          ok3_reg, leap3_reg;
    logic [cdi_pkg::MLEN_W-1:0]    mlen3_reg, lim3_reg;
    logic [cdi_pkg::LIY_W-1:0]     liy3_reg;

    // Stage 4: sum / 7
    logic                          v4_reg;
    cdi_pkg::pipe_t                p4_reg;

    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Stage 1 logic
    logic                          jan_feb;
    logic [26:0]                   qy_prod;
    logic [cdi_pkg::YY_W-1:0]      yy_next;
    logic [cdi_pkg::MONTH_W-1:0]   mm_next;

    assign jan_feb = (in_month == cdi_pkg::MON_JAN) || (in_month == cdi_pkg::MON_FEB)
                     || (in_month == '0);
    assign qy_prod = 27'(in_year) * 27'(cdi_pkg::RECIP100);
    assign yy_next = cdi_pkg::YY_W'(in_year) + cdi_pkg::YEAR_BIAS
                     - cdi_pkg::YY_W'(jan_feb);
    assign mm_next = jan_feb ? in_month + 4'd10 : in_month - 4'd2;

    // Stage 2 logic
    logic [cdi_pkg::YEAR_W-1:0]    r100;
    logic                          leap_next;
    logic [27:0]                   qw_prod;

    assign r100      = y1_reg - cdi_pkg::YEAR_W'(qy1_reg * 7'd100);
    assign leap_next = (r100 == '0) ? (qy1_reg[1:0] == 2'd0) : (y1_reg[1:0] == 2'd0);
    assign qw_prod   = 28'(yy1_reg) * 28'(cdi_pkg::RECIP100);

    // Stage 3 logic
    logic [cdi_pkg::SUM_W-1:0]     sum_next;
    logic [cdi_pkg::MLEN_W-1:0]    mlen_next;
    logic                          ok_next;
    logic [cdi_pkg::DOY_W-1:0]     liy_full;
    logic                          after_feb;

    assign sum_next  = cdi_pkg::SUM_W'(d2_reg) + yy2_reg + (yy2_reg >> 2)
                       - cdi_pkg::SUM_W'(qw2_reg) + cdi_pkg::SUM_W'(qw2_reg >> 2)
                       + cdi_pkg::SUM_W'(cdi_pkg::month_offset(mm2_reg));
    assign mlen_next = cdi_pkg::month_days(m2_reg)
                       + cdi_pkg::MLEN_W'((m2_reg == cdi_pkg::MON_FEB) && leap2_reg);
    assign ok_next   = (m2_reg >= cdi_pkg::MON_JAN) && (m2_reg <= cdi_pkg::MON_DEC)
                       && (d2_reg != '0) && (d2_reg <= mlen_next);
    assign after_feb = leap2_reg && (m2_reg > cdi_pkg::MON_FEB);
    assign liy_full  = (leap2_reg ? 10'd367 : 10'd366)
                       - cdi_pkg::DOY_W'(cdi_pkg::month_start(m2_reg))
                       - cdi_pkg::DOY_W'(d2_reg) - cdi_pkg::DOY_W'(after_feb);

    // Stage 4 logic
    logic [29:0]                   q7_prod;

    assign q7_prod = 30'(s3_reg) * 30'(cdi_pkg::RECIP7);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            y1_reg  <= in_year;
            m1_reg  <= in_month;
            mm1_reg <= mm_next;
            d1_reg  <= in_day;
            yy1_reg <= yy_next;
            qy1_reg <= qy_prod[cdi_pkg::RECIP100_SH +: cdi_pkg::Q100_W];
        end
        if (rdy2 && v1_reg) begin
            leap2_reg <= leap_next;
            m2_reg    <= m1_reg;
            mm2_reg   <= mm1_reg;
            d2_reg    <= d1_reg;
            yy2_reg   <= yy1_reg;
            qw2_reg   <= qw_prod[cdi_pkg::RECIP100_SH +: cdi_pkg::Q100_W];
        end
        if (rdy3 && v2_reg) begin
            s3_reg    <= sum_next;
            ok3_reg   <= ok_next;
            leap3_reg <= leap2_reg;
            mlen3_reg <= mlen_next;
            lim3_reg  <= mlen_next - d2_reg + 5'd1;
            liy3_reg  <= liy_full[cdi_pkg::LIY_W-1:0];
        end
        if (rdy4 && v3_reg) begin
            p4_reg.sum        <= s3_reg;
            p4_reg.q7         <= q7_prod[cdi_pkg::RECIP7_SH +: cdi_pkg::Q7_W];
            p4_reg.date_ok    <= ok3_reg;
            p4_reg.leap       <= leap3_reg;
            p4_reg.mlen       <= mlen3_reg;
            p4_reg.left_month <= lim3_reg;
            p4_reg.left_year  <= liy3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = p4_reg;

endmodule

### src/calendar_date_info_top.sv
// calendar_date_info_top: Gregorian facts for one date per beat.
// Throughput: one beat per cycle while m_tready is high; four arithmetic stages
// plus the output register, each stage holds its own valid bit so bubbles are
// squeezed out.
// Reset (aresetn low, synchronous) empties every stage; data registers are not cleared.
module calendar_date_info_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [13:0] year, [17:14] month, [22:18] day, [23] zero
    input  logic [cdi_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] date_valid, [1] leap_year, [6:2] month_length, [9:7] weekday,
    // [10] end_of_week, [11] weekend_flag, [12] business_day,
    // [15:13] left_in_week, [20:16] left_in_month, [29:21] left_in_year,
    // [31:30] zero
    output logic [cdi_pkg::M_DATA_W-1:0]  m_tdata
);

    logic            pipe_valid;
    logic            pipe_ready;
    cdi_pkg::pipe_t  pipe_data;

    logic              m_valid_reg;
    cdi_pkg::result_t  m_data_reg;
    cdi_pkg::result_t  m_data_next;

    // Arithmetic stages: leap test, weekday sum, sum / 7
    cdi_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_year   (s_tdata[13:0]),
        .in_month  (s_tdata[17:14]),
        .in_day    (s_tdata[22:18]),
        .out_valid (pipe_valid),
        .out_ready (pipe_ready),
        .out_data  (pipe_data)
    );

    // Output stage may load whenever it is empty or its beat is being taken
    assign pipe_ready = !m_valid_reg || m_tready;

    // Final stage: remainder of the weekday sum, weekday flags, zeroing of
    // invalid dates.
    logic [cdi_pkg::SUM_W-1:0] rem_full;
    logic [cdi_pkg::WD_W-1:0]  wd;
    logic                      wkend;

    assign rem_full = pipe_data.sum - cdi_pkg::SUM_W'(pipe_data.q7 * 3'd7);
    assign wd       = rem_full[cdi_pkg::WD_W-1:0];
    assign wkend    = (wd == cdi_pkg::WD_FRI) || (wd == cdi_pkg::WD_SAT);

    always_comb begin
        m_data_next = '0;
        if (pipe_data.date_ok) begin
            m_data_next.date_valid    = 1'b1;
            m_data_next.leap_year     = pipe_data.leap;
            m_data_next.month_length  = pipe_data.mlen;
            m_data_next.weekday       = wd;
            m_data_next.end_of_week   = (wd == cdi_pkg::WD_SAT);
            m_data_next.weekend_flag  = wkend;
            m_data_next.business_day  = !wkend;
            m_data_next.left_in_week  = cdi_pkg::WD_SAT - wd;
            m_data_next.left_in_month = pipe_data.left_month;
            m_data_next.left_in_year  = pipe_data.left_year;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_ready) begin
            m_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ready && pipe_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An invalid date carries no other bits
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.date_valid) |-> (m_data_reg == '0))
        else $error("invalid date beat has nonzero fields");

    // Weekday stays in range for a valid date
    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.date_valid) |-> (m_data_reg.weekday <= cdi_pkg::WD_SAT))
        else $error("weekday out of range");

    // Weekday flags agree with each other
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.date_valid) |->
        ((m_data_reg.business_day != m_data_reg.weekend_flag)
         && (!m_data_reg.end_of_week || m_data_reg.weekend_flag)))
        else $error("weekday flags disagree");

    // A held result beat does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (m_valid_reg && $stable(m_data_reg)))
        else $error("stalled result beat changed");

    // Days left in the month never exceed the month length
    a_left_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.date_valid) |->
        ((m_data_reg.left_in_month <= m_data_reg.month_length)
         && (m_data_reg.left_in_month != '0)))
        else $error("left_in_month out of range");

endmodule
